// File: rtl/core/ssf_pkg.sv
// Shared types and constants for the first-match substring search block.
package ssf_pkg;

  // Field widths fixed by the register map and the item formats
  localparam int LEN_W         = 6;
  localparam int START_W       = 16;
  localparam int MATCH_W       = 16;
  localparam int WORD_W        = 64;
  localparam int PATTERN_WORDS = 4;
  localparam int PATTERN_BYTES = 32;
  localparam int PB_IDX_W      = 5;
  localparam int CFG_IDX_W     = 3;

  typedef logic [7:0] byte_t;
  typedef logic [PATTERN_BYTES-1:0][7:0] pat_bytes_t;
  typedef logic [PATTERN_WORDS-1:0][WORD_W-1:0] pat_words_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_START_INDEX    = 3'd1,
    REG_PATTERN_WORD_0 = 3'd2,
    REG_PATTERN_WORD_1 = 3'd3,
    REG_PATTERN_WORD_2 = 3'd4,
    REG_PATTERN_WORD_3 = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_text_byte;
  } in_t;

  typedef struct packed {
    logic               found;
    logic [MATCH_W-1:0] match_index;
  } out_t;

endpackage

// File: rtl/core/ssf_cell.sv
// One window cell: holds a text byte, passes it on, and checks it against its pattern byte.
module ssf_cell #(
  parameter int IDX    = 0,
  parameter int LEN_CW = 7
) (
  input  logic                clk,
  input  logic                shift_en,
  input  ssf_pkg::byte_t      byte_in,
  input  ssf_pkg::pat_bytes_t pattern,
  input  logic [LEN_CW-1:0]   pat_len,
  output ssf_pkg::byte_t      byte_out,
  output logic                cell_ok
);
  import ssf_pkg::*;

  byte_t             byte_r;
  logic              active;
  logic [LEN_CW-1:0] tgt;
  logic              in_range;
  byte_t             expect_byte;

  // Pick the pattern byte that lines up with this window slot
  assign active   = pat_len > LEN_CW'(IDX);
  assign tgt      = pat_len - LEN_CW'(IDX) - LEN_CW'(1);
  assign in_range = (tgt >> PB_IDX_W) == '0;

  always_comb begin
    if (in_range) begin
      expect_byte = pattern[tgt[PB_IDX_W-1:0]];
    end else begin
      expect_byte = '0;
    end
  end

  // Compare the byte this slot takes on the current transfer
  assign cell_ok = !active || (byte_in == expect_byte);

  // Advance the window on every transfer
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

endmodule

// File: rtl/core/ssf_out_buf.sv
// Result register with a one-entry skid stage between the search logic and the output.
module ssf_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  ssf_pkg::out_t res_data,
  output logic          space_ok,
  output logic          out_valid,
  input  logic          out_ready,
  output ssf_pkg::out_t out_data
);
  import ssf_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  out_t out_data_r, out_data_nxt;
  out_t skid_data_r, skid_data_nxt;
  logic out_take;

  assign out_take = out_valid_r && out_ready;

  // Refill the output register from the skid stage first, else from a new result
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = res_valid;
        skid_data_nxt  = res_data;
      end else begin
        out_valid_nxt  = res_valid;
        out_data_nxt   = res_data;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_data;
    end
  end

  // Hold valid flags under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign space_ok  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A parked result always has one ahead of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without output entry");

  // A result offered while full would be lost
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !skid_valid_r)
    else $error("result offered while skid stage full");

endmodule

// File: rtl/core/substring_search_first_core.sv
// Top level of the streaming first-match substring search.
//
// Text streams in on in_valid/in_ready, one byte per transfer, with
// last_text_byte marking the end of a text. The pattern (up to 32 bytes),
// its length and the earliest allowed start position are written on the
// cfg_ port between texts. Each byte shifts into a row of MAX_PATTERN
// window cells; every cell compares its byte against the pattern byte that
// lines up with it, and the row's results are combined in the same cycle.
// Throughput is one byte per cycle while in_ready is high. A result (found
// with its start position, or not found on the last byte) is registered in
// the output stage before it shows on out_valid. Each text gives at most one
// result; the last byte then clears the position counter and starts a new search.
// Reset empties the output stage and restores an empty pattern, start
// position 0 and position counter 0. When the receiver stalls, one result
// waits in the output register and one more in a skid stage; in_ready
// drops only while the skid stage is occupied.
module substring_search_first_core #(
  parameter int MAX_PATTERN   = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ssf_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ssf_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [ssf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssf_pkg::WORD_W-1:0]       cfg_data
);
  import ssf_pkg::*;

  localparam int LEN_CW = ($clog2(MAX_PATTERN + 1) > LEN_W) ?
                          $clog2(MAX_PATTERN + 1) : LEN_W;
  localparam int CW     = ((POSITION_BITS > START_W) ? POSITION_BITS : START_W) + 1;

  // Configuration registers
  logic [LEN_W-1:0]   len_r;
  logic [START_W-1:0] start_r;
  pat_words_t         pat_words_r;
  pat_bytes_t         pat_bytes;

  // Search state
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     done_r, done_nxt;

  logic              in_fire;
  logic [LEN_CW-1:0] len_c;
  logic [MAX_PATTERN-1:0] cell_ok;
  byte_t             chain [MAX_PATTERN+1];
  logic              saturated;
  logic [CW-1:0]     pos_ext, len_ext, begin_pos;
  logic              hit;
  logic              res_valid;
  out_t              res_data;
  logic              space_ok;

  assign in_ready = space_ok;
  assign in_fire  = in_valid && in_ready;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      start_r     <= '0;
      pat_words_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LENGTH: len_r          <= cfg_data[LEN_W-1:0];
        REG_START_INDEX:    start_r        <= cfg_data[START_W-1:0];
        REG_PATTERN_WORD_0: pat_words_r[0] <= cfg_data;
        REG_PATTERN_WORD_1: pat_words_r[1] <= cfg_data;
        REG_PATTERN_WORD_2: pat_words_r[2] <= cfg_data;
        REG_PATTERN_WORD_3: pat_words_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pat_bytes = pat_words_r;

  // Clamp the length to the window depth
  always_comb begin
    if (LEN_CW'(len_r) > LEN_CW'(MAX_PATTERN)) begin
      len_c = LEN_CW'(MAX_PATTERN);
    end else begin
      len_c = LEN_CW'(len_r);
    end
  end

  // Window row: cell 0 takes the incoming byte
  assign chain[0] = in_data.text_byte;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    ssf_cell #(
      .IDX    (g),
      .LEN_CW (LEN_CW)
    ) u_cell (
      .clk      (clk),
      .shift_en (in_fire),
      .byte_in  (chain[g]),
      .pattern  (pat_bytes),
      .pat_len  (len_c),
      .byte_out (chain[g+1]),
      .cell_ok  (cell_ok[g])
    );
  end

  // Match decision for the byte on the input
  assign saturated = pos_r == '1;
  assign pos_ext   = CW'(pos_r) + CW'(1);
  assign len_ext   = CW'(len_c);
  assign begin_pos = pos_ext - len_ext;

  always_comb begin
    if (len_c == '0) begin
      hit = pos_r == '0;
    end else begin
      hit = !saturated && (pos_ext >= len_ext) &&
            (begin_pos >= CW'(start_r)) && (&cell_ok);
    end
  end

  // Form the result of this transfer; an empty pattern always reports index 0
  always_comb begin
    res_valid = 1'b0;
    res_data  = '0;
    if (in_fire && !done_r) begin
      if (hit) begin
        res_valid            = 1'b1;
        res_data.found       = 1'b1;
        res_data.match_index = (len_c == '0) ? '0 : begin_pos[MATCH_W-1:0];
      end else if (in_data.last_text_byte) begin
        res_valid = 1'b1;
      end
    end
  end

  // Advance position and done flag; drop both at the end of a text
  always_comb begin
    pos_nxt  = pos_r;
    done_nxt = done_r;
    if (in_fire) begin
      if (in_data.last_text_byte) begin
        pos_nxt  = '0;
        done_nxt = 1'b0;
      end else begin
        done_nxt = done_r || hit;
        if (!saturated) begin
          pos_nxt = pos_r + POSITION_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      done_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      done_r <= done_nxt;
    end
  end

  ssf_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The end of a text restarts the search
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last_text_byte |=> pos_r == '0 && !done_r)
    else $error("state not cleared after last byte");

  // A saturated counter stays saturated within a text
  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && saturated && !in_data.last_text_byte |=> pos_r == '1)
    else $error("position counter left saturation");

  // No second result once a text has reported
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !res_valid)
    else $error("second result in one text");

endmodule
